// ===== hdl/cad_pkg.sv =====
// Shared types, codes and decode helpers for the corewar argument decoder.
package cad_pkg;

   // Arena geometry
   localparam int ARENA_BYTES_DEFAULT = 4096;
   localparam int ADDR_W              = 12;
   localparam int ADDR_MAX            = (1 << ADDR_W) - 1;

   // Item function codes
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_DECODE = 1'b1;

   // Argument type codes
   localparam logic [1:0] TYPE_NONE = 2'd0;
   localparam logic [1:0] TYPE_REG  = 2'd1;
   localparam logic [1:0] TYPE_DIR  = 2'd2;
   localparam logic [1:0] TYPE_IND  = 2'd3;

   // Opcodes in the standard order
   localparam logic [4:0] OP_LIVE  = 5'd1;
   localparam logic [4:0] OP_LD    = 5'd2;
   localparam logic [4:0] OP_ST    = 5'd3;
   localparam logic [4:0] OP_ADD   = 5'd4;
   localparam logic [4:0] OP_SUB   = 5'd5;
   localparam logic [4:0] OP_AND   = 5'd6;
   localparam logic [4:0] OP_OR    = 5'd7;
   localparam logic [4:0] OP_XOR   = 5'd8;
   localparam logic [4:0] OP_ZJMP  = 5'd9;
   localparam logic [4:0] OP_FORK  = 5'd12;
   localparam logic [4:0] OP_LFORK = 5'd15;
   localparam logic [4:0] OP_AFF   = 5'd16;

   // Argument widths in bytes
   localparam logic [2:0] WIDTH_NONE  = 3'd0;
   localparam logic [2:0] WIDTH_BYTE  = 3'd1;
   localparam logic [2:0] WIDTH_SHORT = 3'd2;
   localparam logic [2:0] WIDTH_WORD  = 3'd4;

   typedef struct packed {
      logic        func;
      logic [11:0] address;
      logic [7:0]  data;
      logic [4:0]  opcode;
   } cad_req_type;

   typedef struct packed {
      logic [1:0]         arg_type_a;
      logic [1:0]         arg_type_b;
      logic [1:0]         arg_type_c;
      logic signed [31:0] arg_value_a;
      logic signed [31:0] arg_value_b;
      logic signed [31:0] arg_value_c;
      logic [1:0]         arg_count;
   } cad_rsp_type;

   // Opcodes with one direct argument and no coding byte
   function automatic logic is_single(input logic [4:0] op);
      return op inside {OP_LIVE, OP_ZJMP, OP_FORK, OP_LFORK};
   endfunction

   // Bytes fetched for a direct argument of this opcode
   function automatic logic [2:0] direct_width(input logic [4:0] op);
      logic [2:0] w;
      if (op inside {OP_LIVE, OP_LD, OP_AND, OP_OR, OP_XOR}) begin
         w = WIDTH_WORD;
      end else if (op inside {OP_ST, OP_ADD, OP_SUB, OP_AFF}) begin
         w = WIDTH_NONE;
      end else begin
         w = WIDTH_SHORT;
      end
      return w;
   endfunction

   // Bytes fetched for one argument
   function automatic logic [2:0] arg_width(input logic [1:0] t, input logic [2:0] dw);
      logic [2:0] w;
      case (t)
         TYPE_REG: w = WIDTH_BYTE;
         TYPE_IND: w = WIDTH_SHORT;
         TYPE_DIR: w = dw;
         default:  w = WIDTH_NONE;
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/corewar_argument_decoder.sv =====
// Top level of the corewar argument decoder: arena, sequencer and result register.
//
//   channel  dir  ports                               transfer
//   req      in   req_valid req_ready req_payload     one write or decode item
//   rsp      out  rsp_valid rsp_ready rsp_payload     one decoded argument set
//
// A decode fetches B argument bytes (0 to 12), one a cycle, through the
// arena's single memory port. After reset the whole arena is swept to zero;
// req_ready stays low until the sweep is done.
// The result register holds one finished decode; a stalled rsp side holds
// the sequencer at the end of the next decode. Writes are taken only while
// the sequencer is idle, so none while it is held.
module corewar_argument_decoder #(
   parameter int ARENA_BYTES = cad_pkg::ARENA_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cad_pkg::cad_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cad_pkg::cad_rsp_type rsp_payload
);
   import cad_pkg::*;

   localparam int AW = $clog2(ARENA_BYTES);

   logic          done_valid;
   logic          done_take;
   cad_rsp_type   done_payload;
   logic          mem_we;
   logic [AW-1:0] mem_addr;
   logic [7:0]    mem_wdata;
   logic [7:0]    mem_rdata;

   logic          rsp_valid_ff, rsp_valid_in;
   cad_rsp_type   rsp_payload_ff;

   cad_arena_ram #(
      .DEPTH (ARENA_BYTES)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   cad_fetch_seq #(
      .ARENA_BYTES (ARENA_BYTES)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .done_valid   (done_valid),
      .done_payload (done_payload),
      .done_take    (done_take),
      .mem_we       (mem_we),
      .mem_addr     (mem_addr),
      .mem_wdata    (mem_wdata),
      .mem_rdata    (mem_rdata)
   );

   // Result register loads when empty or emptying this cycle
   assign done_take = done_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done_take) begin
         rsp_payload_ff <= done_payload;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== hdl/cad_arena_ram.sv =====
// Single-port byte arena with registered read data.
module cad_arena_ram #(
   parameter int DEPTH = cad_pkg::ARENA_BYTES_DEFAULT,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [7:0]    wdata,
   output logic [7:0]    rdata
);
   import cad_pkg::*;

   logic [7:0] mem [0:DEPTH-1];
   logic [7:0] rdata_ff;

   // Write and read-first access on the one port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/cad_fetch_seq.sv =====
// Sequencer: arena clearing pass, byte writes and the argument fetch of a decode.
module cad_fetch_seq #(
   parameter int ARENA_BYTES = cad_pkg::ARENA_BYTES_DEFAULT,
   localparam int AW         = $clog2(ARENA_BYTES)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cad_pkg::cad_req_type req_payload,
   output logic                 done_valid,
   output cad_pkg::cad_rsp_type done_payload,
   input  logic                 done_take,
   output logic                 mem_we,
   output logic [AW-1:0]        mem_addr,
   output logic [7:0]           mem_wdata,
   input  logic [7:0]           mem_rdata
);
   import cad_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_HEAD  = 3'd2;
   localparam logic [2:0] ST_CODE  = 3'd3;
   localparam logic [2:0] ST_ARGS  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   localparam logic [AW-1:0] LAST_ADDR = AW'(ARENA_BYTES - 1);

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [3:0]    n_ff, n_in;
   logic [3:0]    e0_ff, e0_in, e1_ff, e1_in, e2_ff, e2_in;
   logic          single_ff, single_in;
   logic [2:0]    dw_ff, dw_in;
   logic [1:0]    types_ff [0:2];
   logic [1:0]    types_in [0:2];
   logic [2:0]    w_ff [0:2];
   logic [2:0]    w_in [0:2];
   logic [31:0]   val_ff [0:2];
   logic [31:0]   val_in [0:2];

   logic [ADDR_W-1:0] red;
   logic [AW-1:0]     start;
   logic [1:0]        code_types [0:2];
   logic [2:0]        code_w [0:2];
   logic [1:0]        sel;
   logic [31:0]       ext [0:2];
   logic [1:0]        count;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
      return (a == LAST_ADDR) ? '0 : a + AW'(1);
   endfunction

   // Address modulo arena size by conditional subtraction of shifted multiples
   always_comb begin
      red = req_payload.address;
      for (int k = 6; k >= 0; k--) begin
         if ((ARENA_BYTES << k) <= ADDR_MAX) begin
            if (32'(red) >= (ARENA_BYTES << k)) begin
               red = red - ADDR_W'(ARENA_BYTES << k);
            end
         end
      end
      start = AW'(red);
   end

   // Types and widths seen in the coding-byte cycle
   always_comb begin
      if (single_ff) begin
         code_types[0] = TYPE_DIR;
         code_types[1] = TYPE_NONE;
         code_types[2] = TYPE_NONE;
      end else begin
         code_types[0] = mem_rdata[7:6];
         code_types[1] = mem_rdata[5:4];
         code_types[2] = mem_rdata[3:2];
      end
      for (int i = 0; i < 3; i++) begin
         code_w[i] = arg_width(code_types[i], dw_ff);
      end
   end

   // Which argument the arriving byte belongs to
   always_comb begin
      if (n_ff < e0_ff) begin
         sel = 2'd0;
      end else if (n_ff < e1_ff) begin
         sel = 2'd1;
      end else begin
         sel = 2'd2;
      end
   end

   // Next-state logic
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      ptr_in    = ptr_ff;
      n_in      = n_ff;
      e0_in     = e0_ff;
      e1_in     = e1_ff;
      e2_in     = e2_ff;
      single_in = single_ff;
      dw_in     = dw_ff;
      for (int i = 0; i < 3; i++) begin
         types_in[i] = types_ff[i];
         w_in[i]     = w_ff[i];
         val_in[i]   = val_ff[i];
      end
      case (state_ff)
         ST_CLEAR: begin
            clr_in = wrap_inc(clr_ff);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid && req_payload.func == FUNC_DECODE) begin
               single_in = is_single(req_payload.opcode);
               dw_in     = direct_width(req_payload.opcode);
               // one-argument opcodes read a dummy byte at pc in the coding slot
               ptr_in    = single_in ? start : wrap_inc(start);
               state_in  = ST_HEAD;
            end
         end
         ST_HEAD: begin
            ptr_in   = wrap_inc(ptr_ff);
            state_in = ST_CODE;
         end
         ST_CODE: begin
            ptr_in = wrap_inc(ptr_ff);
            for (int i = 0; i < 3; i++) begin
               types_in[i] = code_types[i];
               w_in[i]     = code_w[i];
               val_in[i]   = '0;
            end
            e0_in    = {1'b0, code_w[0]};
            e1_in    = e0_in + {1'b0, code_w[1]};
            e2_in    = e1_in + {1'b0, code_w[2]};
            n_in     = '0;
            state_in = (e2_in == 4'd0) ? ST_DONE : ST_ARGS;
         end
         ST_ARGS: begin
            ptr_in = wrap_inc(ptr_ff);
            for (int i = 0; i < 3; i++) begin
               if (sel == 2'(i)) begin
                  val_in[i] = {val_ff[i][23:0], mem_rdata};
               end
            end
            n_in = n_ff + 4'd1;
            if (n_in == e2_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (done_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      n_ff      <= n_in;
      e0_ff     <= e0_in;
      e1_ff     <= e1_in;
      e2_ff     <= e2_in;
      single_ff <= single_in;
      dw_ff     <= dw_in;
      for (int i = 0; i < 3; i++) begin
         types_ff[i] <= types_in[i];
         w_ff[i]     <= w_in[i];
         val_ff[i]   <= val_in[i];
      end
   end

   // Memory port: sweep, byte write, or fetch pointer
   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = req_payload.data;
      mem_addr  = ptr_ff;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_wdata = '0;
         mem_addr  = clr_ff;
      end else if (state_ff == ST_IDLE) begin
         mem_we   = req_valid && req_payload.func == FUNC_WRITE;
         mem_addr = start;
      end
   end

   // Sign extension of short values and leading argument count
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ext[i] = (w_ff[i] == WIDTH_SHORT) ? {{16{val_ff[i][15]}}, val_ff[i][15:0]} : val_ff[i];
      end
      if (types_ff[0] == TYPE_NONE) begin
         count = 2'd0;
      end else if (types_ff[1] == TYPE_NONE) begin
         count = 2'd1;
      end else if (types_ff[2] == TYPE_NONE) begin
         count = 2'd2;
      end else begin
         count = 2'd3;
      end
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign done_valid = (state_ff == ST_DONE);

   always_comb begin
      done_payload.arg_type_a  = types_ff[0];
      done_payload.arg_type_b  = types_ff[1];
      done_payload.arg_type_c  = types_ff[2];
      done_payload.arg_value_a = ext[0];
      done_payload.arg_value_b = ext[1];
      done_payload.arg_value_c = ext[2];
      done_payload.arg_count   = count;
   end

   // Byte counter never runs past the last argument byte
   a_args_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ARGS |-> n_ff < e2_ff && e0_ff <= e1_ff && e1_ff <= e2_ff)
      else $error("argument byte counter past end");

   // Reduced address always lies inside the arena
   a_red_range: assert property (@(posedge clock) disable iff (reset)
      req_valid |-> 32'(red) < ARENA_BYTES)
      else $error("reduced address outside arena");

   // Fetch pointer wraps inside the arena
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HEAD || state_ff == ST_CODE || state_ff == ST_ARGS)
      |-> ptr_ff <= LAST_ADDR)
      else $error("fetch pointer outside arena");

   // No arena write in the coding-byte state that follows the head fetch
   a_no_write_in_fetch: assert property (@(posedge clock) disable iff (reset)
      $past(state_ff == ST_HEAD) |-> !mem_we && state_ff == ST_CODE)
      else $error("arena write during fetch");

endmodule
